// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps

package skt_pkg;

   localparam int unsigned DEPTH   = 32;
   localparam int unsigned IDX_W   = $clog2(DEPTH);
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned SCORE_W = 32;
   localparam int unsigned ENTRY_W = KEY_W + SCORE_W;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned COUNT_W = 6;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic signed [KEY_W-1:0] key;
      logic [SCORE_W-1:0]      score_bits;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [KEY_W-1:0] entry_key;
      logic [SCORE_W-1:0]      entry_score;
      logic [COUNT_W-1:0]      entry_count;
      logic                    last;
   } rsp_type;

endpackage

// ===== rtl/skt_ram.sv =====
`timescale 1ns / 1ps

module skt_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned WIDTH = 64,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sorted_key_table.sv =====
`timescale 1ns / 1ps

// channel     | ports                        | handshake
// ------------+------------------------------+-------------------------------------
// request     | start, busy, req_payload     | taken when start high and busy low
// response    | rsp_strobe, rsp_payload      | one cycle per result, never stalled
//
// one table entry is visited per cycle through the single-port read of the entry
// memory: insert walks down from the top entry to the first key below the new key or
// the bottom, delete and dump visit every held entry, refusals visit none
// dump streams one result per cycle, back to back, with last on the final entry
// reset clears the state, entry count and control flags; entry memory is never cleared
// the receiver cannot stall, so each result is registered and leaves in the cycle after it is formed
module sorted_key_table
   import skt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_DELETE,
      S_DUMP
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [SCORE_W-1:0]      score_ff;
   logic                    rd_valid_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    found_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff;

   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ENTRY_W-1:0]      wr_data;

   logic signed [KEY_W-1:0] rd_key;
   logic [SCORE_W-1:0]      rd_score;
   logic                    key_ge;
   logic                    key_eq;
   logic                    table_full;
   logic                    table_empty;
   logic [IDX_W-1:0]        last_idx;

   function automatic rsp_type make_rsp(logic [STAT_W-1:0] status,
                                        logic signed [KEY_W-1:0] entry_key,
                                        logic [SCORE_W-1:0] entry_score,
                                        logic [CNT_W-1:0] count,
                                        logic last);
      rsp_type r;
      r.status      = status;
      r.entry_key   = entry_key;
      r.entry_score = entry_score;
      r.entry_count = COUNT_W'(count);
      r.last        = last;
      return r;
   endfunction

   assign rd_key      = rd_data[ENTRY_W-1:SCORE_W];
   assign rd_score    = rd_data[SCORE_W-1:0];
   assign key_ge      = (rd_key >= key_ff);
   assign key_eq      = (rd_key == key_ff);
   assign table_full  = (count_ff == CNT_W'(DEPTH));
   assign table_empty = (count_ff == '0);
   assign last_idx    = IDX_W'(count_ff - 1'b1);

   skt_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // insert walks down from the top entry, moving each key at or above the new key up one slot;
   // delete walks up from the bottom, pulling entries down once the match is passed
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff;
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !table_empty) begin
               if (req_payload.operation == OP_INSERT && !table_full) begin
                  rd_en   = 1'b1;
                  rd_addr = last_idx;
               end else if (req_payload.operation == OP_DELETE ||
                            req_payload.operation == OP_DUMP) begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end
            end
         end
         S_INSERT: begin
            wr_en = 1'b1;
            if (!rd_valid_ff) begin
               wr_addr = '0;
               wr_data = {key_ff, score_ff};
            end else if (key_ge) begin
               wr_addr = IDX_W'(rd_idx_ff + 1'b1);
               if (rd_idx_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(rd_idx_ff - 1'b1);
               end
            end else begin
               wr_addr = IDX_W'(rd_idx_ff + 1'b1);
               wr_data = {key_ff, score_ff};
            end
         end
         S_DELETE: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(rd_idx_ff - 1'b1);
            end
            if (rd_idx_ff != last_idx) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(rd_idx_ff + 1'b1);
            end
         end
         S_DUMP: begin
            if (rd_idx_ff != last_idx) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(rd_idx_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_valid_ff   <= rd_en;
         if (rd_en) begin
            rd_idx_ff <= rd_addr;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  key_ff   <= req_payload.key;
                  score_ff <= req_payload.score_bits;
                  found_ff <= 1'b0;
                  priority if (req_payload.operation == OP_INSERT) begin
                     if (table_full) begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_ff <= make_rsp(ST_FULL, req_payload.key, '0, count_ff, 1'b1);
                     end else begin
                        state_ff <= S_INSERT;
                     end
                  end else if (req_payload.operation == OP_DELETE ||
                               req_payload.operation == OP_DUMP) begin
                     if (table_empty) begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_ff <= make_rsp(ST_EMPTY, req_payload.key, '0, count_ff, 1'b1);
                     end else if (req_payload.operation == OP_DELETE) begin
                        state_ff <= S_DELETE;
                     end else begin
                        state_ff <= S_DUMP;
                     end
                  end else begin
                     // unused operation code: no result
                  end
               end
            end
            S_INSERT: begin
               if (!rd_valid_ff || !key_ge) begin
                  count_ff      <= CNT_W'(count_ff + 1'b1);
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff <= make_rsp(ST_DONE, key_ff, '0, CNT_W'(count_ff + 1'b1), 1'b1);
                  state_ff      <= S_IDLE;
               end
            end
            S_DELETE: begin
               if (!found_ff && key_eq) begin
                  found_ff <= 1'b1;
               end
               if (rd_idx_ff == last_idx) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
                  if (found_ff || key_eq) begin
                     count_ff <= CNT_W'(count_ff - 1'b1);
                     rsp_ff <= make_rsp(ST_DONE, key_ff, '0,
                                        CNT_W'(count_ff - 1'b1), 1'b1);
                  end else begin
                     rsp_ff <= make_rsp(ST_NOTFOUND, key_ff, '0, count_ff, 1'b1);
                  end
               end
            end
            S_DUMP: begin
               rsp_strobe_ff <= 1'b1;
               rsp_ff <= make_rsp(ST_ENTRY, rd_key, rd_score, count_ff,
                                  rd_idx_ff == last_idx);
               if (rd_idx_ff == last_idx) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.operation == OP_INSERT && table_full
      |=> rsp_strobe && rsp_payload.status == ST_FULL && $stable(count_ff))
      else $error("insert into full table not refused");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |=> rsp_strobe)
      else $error("dump stream broken before last entry");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_INSERT || state_ff == S_DELETE)
      else $error("entry memory written outside insert or delete");

endmodule

// ===== verif/tb_sorted_key_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table;
   import skt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 150;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

   // mirror of the table contents plus the results still owed by the block
   class key_table_tracker;
      logic signed [KEY_W-1:0] keys[$];
      logic [SCORE_W-1:0]      scores[$];
      rsp_type                 owed_rsps[$];
      int                      errors = 0;

      function void apply_op(req_type r);
         int      pos;
         int      n;
         int      i;
         rsp_type e;
         n = keys.size();
         e = '0;
         e.entry_key = r.key;
         e.last = 1'b1;
         case (r.operation)
            OP_INSERT: begin
               if (n >= DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  // equal keys land in front of the ones already held
                  pos = 0;
                  while (pos < n && keys[pos] < $signed(r.key))
                     pos++;
                  keys.insert(pos, r.key);
                  scores.insert(pos, r.score_bits);
                  e.status = ST_DONE;
               end
            end
            OP_DELETE: begin
               if (n == 0) begin
                  e.status = ST_EMPTY;
               end else begin
                  pos = 0;
                  while (pos < n && keys[pos] !== r.key)
                     pos++;
                  if (pos == n) begin
                     e.status = ST_NOTFOUND;
                  end else begin
                     keys.delete(pos);
                     scores.delete(pos);
                     e.status = ST_DONE;
                  end
               end
            end
            OP_DUMP: begin
               if (n == 0) begin
                  e.status = ST_EMPTY;
               end else begin
                  for (i = 0; i < n; i++) begin
                     e.status      = ST_ENTRY;
                     e.entry_key   = keys[i];
                     e.entry_score = scores[i];
                     e.entry_count = COUNT_W'(n);
                     e.last        = (i == n - 1);
                     owed_rsps.push_back(e);
                  end
                  return;
               end
            end
            default: return; // unused code, block ignores it
         endcase
         e.entry_count = COUNT_W'(keys.size());
         owed_rsps.push_back(e);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type e;
         if (owed_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction: status=%0d key=%0d score=%h count=%0d last=%0b",
                     $time, got.status, $signed(got.entry_key), got.entry_score,
                     got.entry_count, got.last);
            return;
         end
         e = owed_rsps.pop_front();
         if (got !== e) begin
            errors++;
            $display("%0t: mismatch: expected status=%0d key=%0d score=%h count=%0d last=%0b",
                     $time, e.status, $signed(e.entry_key), e.entry_score,
                     e.entry_count, e.last);
            $display("%0t:           actual status=%0d key=%0d score=%h count=%0d last=%0b",
                     $time, got.status, $signed(got.entry_key), got.entry_score,
                     got.entry_count, got.last);
         end
      endfunction

      function int owed_count();
         return owed_rsps.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   key_table_tracker tracker = new();
   int unsigned      cycle_count = 0;
   int               no_gap_left = 0;

   sorted_key_table u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_rsp(rsp_payload);
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gap_left > 0) begin
         no_gap_left--;
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      // small pool keeps duplicates and delete hits frequent
      if (roll < 45)
         return KEY_W'(int'($urandom_range(0, 15)) - 8);
      if (roll < 65) begin
         case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0001;
            3: return 32'sh7fff_fffe;
            4: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_op(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                          input logic [SCORE_W-1:0] score, input int gap);
      req_type r;
      r.operation  = op;
      r.key        = key;
      r.score_bits = score;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.apply_op(r);
   endtask

   // always advances at least one edge so start is not lowered and raised in one step
   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (tracker.owed_count() != 0);
   endtask

   initial begin
      int    sent;
      int    roll;
      bit    growing;
      logic [OP_W-1:0] op;
      logic signed [KEY_W-1:0] key;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cases, key extremes, duplicates, misses, unused code
      send_op(OP_DUMP,   32'sh8000_0000, 32'hffff_ffff, pick_gap());
      send_op(OP_DELETE, 32'sh7fff_ffff, 32'hffff_ffff, pick_gap());
      send_op(OP_INSERT, 32'sd0,         32'h0000_0000, pick_gap());
      send_op(OP_INSERT, 32'sh8000_0000, 32'hffff_ffff, pick_gap());
      send_op(OP_INSERT, 32'sh7fff_ffff, 32'ha5a5_a5a5, pick_gap());
      send_op(OP_INSERT, -32'sd1,        32'h5a5a_5a5a, pick_gap());
      send_op(OP_INSERT, 32'sd0,         32'h0000_0001, pick_gap());
      send_op(OP_INSERT, 32'sd1,         32'h8000_0000, pick_gap());
      send_op(OP_DUMP,   32'sd0,         32'h0000_0000, pick_gap());
      send_op(OP_DELETE, 32'sd5,         32'h1234_5678, pick_gap());
      send_op(OP_DELETE, 32'sd0,         32'h0000_0000, pick_gap());
      send_op(OP_UNUSED, 32'sd1,         32'hdead_beef, pick_gap());
      send_op(OP_DELETE, 32'sh8000_0000, 32'h0000_0000, pick_gap());
      send_op(OP_DELETE, 32'sh7fff_ffff, 32'h0000_0000, pick_gap());
      send_op(OP_DUMP,   -32'sd1,        32'h0000_0000, pick_gap());
      send_op(OP_DELETE, -32'sd1,        32'h0000_0000, pick_gap());
      send_op(OP_DELETE, 32'sd0,         32'h0000_0000, pick_gap());
      send_op(OP_DELETE, 32'sd1,         32'h0000_0000, pick_gap());
      send_op(OP_DUMP,   32'sh7fff_ffff, 32'h0000_0000, pick_gap());
      send_op(OP_DELETE, 32'sd7,         32'h0000_0000, pick_gap());
      wait_all_results();

      // random: alternate growth toward full and shrink toward empty
      sent = 0;
      growing = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            op = OP_UNUSED;
         end else if (roll < 13) begin
            op = OP_DUMP;
         end else if (growing) begin
            op = (roll < 80) ? OP_INSERT : OP_DELETE;
         end else begin
            op = (roll < 80) ? OP_DELETE : OP_INSERT;
         end

         key = pick_key();
         if (op == OP_DELETE && tracker.keys.size() > 0 && $urandom_range(0, 99) < 75)
            key = tracker.keys[$urandom_range(0, tracker.keys.size() - 1)];

         if ($urandom_range(0, 29) == 0)
            no_gap_left = $urandom_range(10, 25);
         send_op(op, key, $urandom, pick_gap());
         if (op != OP_UNUSED)
            sent++;

         if (growing && tracker.keys.size() >= DEPTH && $urandom_range(0, 99) < 40)
            growing = 1'b0;
         else if (!growing && (tracker.keys.size() == 0 ||
                  (tracker.keys.size() < 10 && $urandom_range(0, 29) == 0)))
            growing = 1'b1;

         if ($urandom_range(0, 24) == 0)
            wait_all_results();
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed_count() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sorted_key_table.f =====
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/sorted_key_table.sv
verif/tb_sorted_key_table.sv
